@@ src/btc_pkg.sv @@
// Package for the blank-run to tab compressor.
// Character codes, field widths, run codes and the controller/datapath structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package btc_pkg;

    localparam int CHAR_W           = 8;
    localparam int TW_W             = 5;
    localparam int MAX_RESULTS      = 39;
    localparam int CNT_W            = $clog2(MAX_RESULTS);
    localparam int SPC_W            = 5;
    localparam int COLUMN_LIMIT_DEF = 256;

    localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

    localparam logic [TW_W-1:0] TAB_WIDTH_RESET = 5'd8;
    localparam logic [TW_W-1:0] TAB_WIDTH_MAX   = 5'd16;

    // Pending-run codes
    localparam logic [1:0] RS_NONE = 2'd0;
    localparam logic [1:0] RS_ONE  = 2'd1;
    localparam logic [1:0] RS_MANY = 2'd2;

    typedef struct packed {
        logic accept;
        logic load_single;
        logic div_step;
        logic calc;
        logic push_tab;
        logic push_space;
        logic push_char;
    } t_btc_cmd;

    typedef struct packed {
        logic [1:0] run_state;
        logic       in_flush;
        logic       in_blank;
        logic       div_last;
        logic       out_free;
        logic       tabs_nz;
        logic       spaces_nz;
        logic       flush_pend;
    } t_btc_sts;

endpackage

`default_nettype wire

@@ src/btc_in_if.sv @@
// Request channel into the compressor: one text byte or a flush marker.
// Depends on btc_pkg for the byte width.
`default_nettype none

interface btc_in_if import btc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] in_char;
    logic              flush;

    modport source (output valid, output in_char, output flush, input ready);
    modport sink   (input valid, input in_char, input flush, output ready);
endinterface

`default_nettype wire

@@ src/btc_out_if.sv @@
// Result channel out of the compressor: one output byte and its last marker.
// Depends on btc_pkg for the byte width.
`default_nettype none

interface btc_out_if import btc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] out_char;
    logic              last;

    modport source (output valid, output out_char, output last, input ready);
    modport sink   (input valid, input out_char, input last, output ready);
endinterface

`default_nettype wire

@@ src/blank_run_to_tab_compressor.sv @@
// Top level of the blank-run to tab compressor: controller plus datapath.
// Depends on btc_pkg, btc_in_if, btc_out_if, btc_ctrl and btc_dp.
//
// Text bytes come in one request at a time on i_in; output bytes leave on o_out,
// each with a last flag on the final byte that a request causes. A single blank
// passes through as one space. Two or more blanks are held until the next
// non-blank byte (newline included), then leave as one tab per tab stop crossed,
// then the leftover spaces, then that byte; a run that crosses no stop leaves as
// its own blank count, and the tab count is trimmed so that one request yields
// at most 39 bytes. A flush request emits any pending run and restarts the line
// at column zero; with nothing pending it produces no output. The column tracks
// every byte, restarts after a newline and holds at COLUMN_LIMIT-1. tab_width is
// written through i_tab_width_we / i_tab_width_wdata (reset 8; zero acts as 1,
// anything above 16 as 16) and is only to be written while the block is idle.
// The block works on one request at a time. A blank that starts or extends a
// run, and a flush with nothing pending, are only accepted; a byte with nothing
// pending is accepted, then loaded into the output register. A byte after a
// single blank emits the space, then the byte; a flush after one emits the space.
// A byte or flush that closes a longer run is accepted, then passes through the
// bit-serial divider that forms column / tab_width and start / tab_width, one
// quotient bit per cycle, CW = clog2(COLUMN_LIMIT) (8 by default) bits long,
// then sets the counts and emits the tabs, the spaces and, for a byte, the byte.
// A stalled o_out holds the emission.
`default_nettype none

module blank_run_to_tab_compressor import btc_pkg::*; #(
    parameter int COLUMN_LIMIT = COLUMN_LIMIT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_tab_width_we,
    input  wire logic [TW_W-1:0] i_tab_width_wdata,
    btc_in_if.sink               i_in,
    btc_out_if.source            o_out
);

    t_btc_cmd cmd;
    t_btc_sts sts;
    logic     in_ready;
    logic     out_valid;
    logic [CHAR_W-1:0] out_char;
    logic     out_last;

    // Sequence each request: accept, divide, set counts, emit tabs/spaces/byte
    btc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold line state, divide, count and drive the output register
    btc_dp #(
        .COLUMN_LIMIT (COLUMN_LIMIT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tab_width_we    (i_tab_width_we),
        .i_tab_width_wdata (i_tab_width_wdata),
        .i_in_char         (i_in.in_char),
        .i_in_flush        (i_in.flush),
        .o_out_valid       (out_valid),
        .i_out_ready       (o_out.ready),
        .o_out_char        (out_char),
        .o_out_last        (out_last),
        .i_cmd             (cmd),
        .o_sts             (sts)
    );

    assign i_in.ready     = in_ready;
    assign o_out.valid    = out_valid;
    assign o_out.out_char = out_char;
    assign o_out.last     = out_last;

endmodule

`default_nettype wire

@@ src/btc_ctrl.sv @@
// Controller of the compressor: sequences accept, divide, count setup and emission.
// Depends on btc_pkg for the command and status structs and run codes.
`default_nettype none

module btc_ctrl import btc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_btc_sts i_sts,
    output t_btc_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_CALC,
        S_EMIT,
        S_CHAR
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.in_flush || !i_sts.in_blank) begin
                        case (i_sts.run_state)
                            RS_MANY: n_state = S_DIV;
                            RS_ONE: begin
                                o_cmd.load_single = 1'b1;
                                n_state           = S_EMIT;
                            end
                            default: n_state = i_sts.in_flush ? S_IDLE : S_CHAR;
                        endcase
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.tabs_nz) begin
                    o_cmd.push_tab = i_sts.out_free;
                end else if (i_sts.spaces_nz) begin
                    o_cmd.push_space = i_sts.out_free;
                end else begin
                    n_state = i_sts.flush_pend ? S_IDLE : S_CHAR;
                end
            end
            S_CHAR: begin
                if (i_sts.out_free) begin
                    o_cmd.push_char = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ src/btc_dp.sv @@
// Datapath of the compressor: column and run state, tab width register,
// bit-serial divider, tab/space counters and the output register.
// Depends on btc_pkg; driven by btc_ctrl through t_btc_cmd.
`default_nettype none

module btc_dp import btc_pkg::*; #(
    parameter int COLUMN_LIMIT = COLUMN_LIMIT_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_tab_width_we,
    input  wire logic [TW_W-1:0]   i_tab_width_wdata,
    input  wire logic [CHAR_W-1:0] i_in_char,
    input  wire logic              i_in_flush,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [CHAR_W-1:0]      o_out_char,
    output logic                   o_out_last,
    input  wire t_btc_cmd          i_cmd,
    output t_btc_sts               o_sts
);

    localparam int CW   = $clog2(COLUMN_LIMIT);
    localparam int DCW  = $clog2(CW);
    localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [CW-1:0]    COL_MAX  = CW'(COLUMN_LIMIT - 1);
    localparam logic [CNT_W-1:0] CAP_BASE = CNT_W'(MAX_RESULTS - 1);

    // Line state
    logic [CW-1:0]   r_column, n_column;
    logic [1:0]      r_run_state, n_run_state;
    logic [CW-1:0]   r_run_start, n_run_start;
    logic [TW_W-1:0] r_tab_width;

    // Snapshot of the request being worked on
    logic [CW-1:0]     r_col_e, r_start_e;
    logic              r_flush;
    logic [CHAR_W-1:0] r_char;

    // Divider
    logic [CW-1:0]   r_dq_c, r_dq_s;
    logic [TW_W-1:0] r_rem_c, r_rem_s;
    logic [DCW-1:0]  r_div_cnt;

    // Emission
    logic [CNT_W-1:0] r_tab_cnt;
    logic [SPC_W-1:0] r_spc_cnt;
    logic              r_out_valid;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    logic [TW_W-1:0] tw;
    logic            in_blank;
    logic            out_free;

    always_comb begin
        if (r_tab_width == '0) begin
            tw = TW_W'(1);
        end else if (r_tab_width > TAB_WIDTH_MAX) begin
            tw = TAB_WIDTH_MAX;
        end else begin
            tw = r_tab_width;
        end
    end

    assign in_blank = (i_in_char == CH_BLANK);
    assign out_free = !r_out_valid || i_out_ready;

    // Next line state for an accepted request
    always_comb begin
        n_column    = r_column;
        n_run_state = r_run_state;
        n_run_start = r_run_start;
        if (i_in_flush) begin
            n_column    = '0;
            n_run_state = RS_NONE;
            n_run_start = '0;
        end else begin
            if (in_blank) begin
                if (r_run_state == RS_NONE) begin
                    n_run_state = RS_ONE;
                    n_run_start = r_column;
                end else begin
                    n_run_state = RS_MANY;
                end
            end else begin
                n_run_state = RS_NONE;
            end
            if (i_in_char == CH_NEWLINE) begin
                n_column = '0;
            end else if (r_column < COL_MAX) begin
                n_column = r_column + CW'(1);
            end
        end
    end

    // One restoring-division step for both dividends
    logic [TW_W:0]   sh_c, sh_s;
    logic            ge_c, ge_s;
    logic [TW_W-1:0] rem_c_n, rem_s_n;

    always_comb begin
        sh_c    = {r_rem_c, r_dq_c[CW-1]};
        sh_s    = {r_rem_s, r_dq_s[CW-1]};
        ge_c    = (sh_c >= {1'b0, tw});
        ge_s    = (sh_s >= {1'b0, tw});
        rem_c_n = ge_c ? TW_W'(sh_c - {1'b0, tw}) : sh_c[TW_W-1:0];
        rem_s_n = ge_s ? TW_W'(sh_s - {1'b0, tw}) : sh_s[TW_W-1:0];
    end

    // Tab and space counts once both quotients are in
    logic [CW-1:0]    tabs_full;
    logic [SPC_W-1:0] spaces;
    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] tabs;

    always_comb begin
        tabs_full = r_dq_c - r_dq_s;
        spaces    = (tabs_full != '0) ? SPC_W'(r_rem_c) : SPC_W'(r_col_e - r_start_e);
        cap       = CAP_BASE - CNT_W'(spaces);
        tabs      = (CMPW'(tabs_full) > CMPW'(cap)) ? cap : CNT_W'(tabs_full);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_run_state <= RS_NONE;
            r_run_start <= '0;
            r_tab_width <= TAB_WIDTH_RESET;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            if (i_tab_width_we) begin
                r_tab_width <= i_tab_width_wdata;
            end
            if (i_cmd.accept) begin
                r_column    <= n_column;
                r_run_state <= n_run_state;
                r_run_start <= n_run_start;
                r_div_cnt   <= '0;
            end else if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DCW'(1);
            end
            if (i_cmd.push_tab || i_cmd.push_space || i_cmd.push_char) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_col_e   <= r_column;
            r_start_e <= r_run_start;
            r_flush   <= i_in_flush;
            r_char    <= i_in_char;
            r_dq_c    <= r_column;
            r_dq_s    <= r_run_start;
            r_rem_c   <= '0;
            r_rem_s   <= '0;
        end else if (i_cmd.div_step) begin
            r_dq_c  <= {r_dq_c[CW-2:0], ge_c};
            r_dq_s  <= {r_dq_s[CW-2:0], ge_s};
            r_rem_c <= rem_c_n;
            r_rem_s <= rem_s_n;
        end

        if (i_cmd.load_single) begin
            r_tab_cnt <= '0;
            r_spc_cnt <= SPC_W'(1);
        end else if (i_cmd.calc) begin
            r_tab_cnt <= tabs;
            r_spc_cnt <= spaces;
        end else if (i_cmd.push_tab) begin
            r_tab_cnt <= r_tab_cnt - CNT_W'(1);
        end else if (i_cmd.push_space) begin
            r_spc_cnt <= r_spc_cnt - SPC_W'(1);
        end

        if (i_cmd.push_tab) begin
            r_out_char <= CH_TAB;
            r_out_last <= r_flush && (r_tab_cnt == CNT_W'(1)) && (r_spc_cnt == '0);
        end else if (i_cmd.push_space) begin
            r_out_char <= CH_BLANK;
            r_out_last <= r_flush && (r_spc_cnt == SPC_W'(1));
        end else if (i_cmd.push_char) begin
            r_out_char <= r_char;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;

    always_comb begin
        o_sts.run_state  = r_run_state;
        o_sts.in_flush   = i_in_flush;
        o_sts.in_blank   = in_blank;
        o_sts.div_last   = (r_div_cnt == DCW'(CW - 1));
        o_sts.out_free   = out_free;
        o_sts.tabs_nz    = (r_tab_cnt != '0);
        o_sts.spaces_nz  = (r_spc_cnt != '0);
        o_sts.flush_pend = r_flush;
    end

endmodule

`default_nettype wire

@@ tb/blank_run_to_tab_compressor_tb.sv @@
// Self-checking testbench for blank_run_to_tab_compressor.
// Drives text requests and tab_width writes, predicts every output byte, checks each one.
// Depends on btc_pkg, btc_in_if, btc_out_if and the compressor RTL.
`timescale 1ns / 100ps

module blank_run_to_tab_compressor_tb;
    import btc_pkg::*;

    localparam int          COLUMN_LIMIT  = COLUMN_LIMIT_DEF;
    localparam int          SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT   = 2_000_000;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } t_out_byte;

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_tab_width_we;
    logic [TW_W-1:0] i_tab_width_wdata;

    btc_in_if  in_if ();
    btc_out_if out_if ();

    blank_run_to_tab_compressor #(
        .COLUMN_LIMIT(COLUMN_LIMIT)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tab_width_we    (i_tab_width_we),
        .i_tab_width_wdata (i_tab_width_wdata),
        .i_in              (in_if),
        .o_out             (out_if)
    );

    always #6 i_clk = ~i_clk;

    // Shadow of the compressor state, kept in step with every accepted request
    logic [TW_W-1:0] model_tab_width;
    int unsigned     model_column;
    logic [1:0]      model_run;
    int unsigned     model_run_start;

    logic [CHAR_W-1:0] burst_bytes[$];   // bytes caused by the request being predicted
    t_out_byte         expected_out[$];  // predicted bytes still waiting on o_out

    int          send_idle_pct;
    int          recv_stall_pct;
    int unsigned requests_sent;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    function automatic void reset_model();
        model_tab_width = TAB_WIDTH_RESET;
        model_column    = 0;
        model_run       = RS_NONE;
        model_run_start = 0;
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum
    function automatic int unsigned effective_tab_width();
        if (model_tab_width == 0) begin
            return 1;
        end
        if (model_tab_width > TAB_WIDTH_MAX) begin
            return TAB_WIDTH_MAX;
        end
        return model_tab_width;
    endfunction

    // Turn the pending run into tabs and spaces at the current column
    function automatic void close_blank_run();
        int unsigned width;
        int unsigned tabs;
        int unsigned spaces;
        if (model_run == RS_ONE) begin
            burst_bytes.push_back(CH_BLANK);
        end else if (model_run == RS_MANY) begin
            width  = effective_tab_width();
            tabs   = model_column / width - model_run_start / width;
            // with no stop crossed the run keeps its own blank count
            spaces = (tabs != 0) ? model_column % width : model_column - model_run_start;
            // trim the tabs so one request never yields more than MAX_RESULTS bytes
            if (tabs > MAX_RESULTS - 1 - spaces) begin
                tabs = MAX_RESULTS - 1 - spaces;
            end
            repeat (tabs) burst_bytes.push_back(CH_TAB);
            repeat (spaces) burst_bytes.push_back(CH_BLANK);
        end
        model_run = RS_NONE;
    endfunction

    function automatic void compress_request(input logic [CHAR_W-1:0] ch, input logic fl);
        burst_bytes.delete();
        if (fl) begin
            close_blank_run();
            model_column    = 0;
            model_run_start = 0;
        end else begin
            if (ch == CH_BLANK) begin
                if (model_run == RS_NONE) begin
                    model_run       = RS_ONE;
                    model_run_start = model_column;
                end else begin
                    model_run = RS_MANY;
                end
            end else begin
                close_blank_run();
                burst_bytes.push_back(ch);
            end
            // a newline restarts the line; otherwise advance and hold at the limit
            if (ch == CH_NEWLINE) begin
                model_column = 0;
            end else if (model_column < COLUMN_LIMIT - 1) begin
                model_column++;
            end
        end
        foreach (burst_bytes[k]) begin
            expected_out.push_back('{out_char: burst_bytes[k],
                                     last: (k == burst_bytes.size() - 1)});
        end
    endfunction

    // ---------------------------------------------------------------------
    // Shared driving tasks
    // ---------------------------------------------------------------------

    // Send one request; valid stays high after acceptance so that back-to-back
    // requests never lower and raise it in the same step.
    task automatic send_request(input logic [CHAR_W-1:0] ch, input logic fl);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.in_char <= ch;
        in_if.flush   <= fl;
        do @(posedge i_clk); while (!in_if.ready);
        compress_request(ch, fl);
        requests_sent++;
    endtask

    // Hold off the sender until every predicted byte has left, then let the
    // block finish any request that produces no output.
    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the block is idle
    task automatic write_tab_width(input logic [TW_W-1:0] width);
        i_tab_width_we    <= 1'b1;
        i_tab_width_wdata <= width;
        @(posedge i_clk);
        i_tab_width_we  <= 1'b0;
        model_tab_width  = width;
    endtask

    function automatic logic [CHAR_W-1:0] rand_text_char();
        return CHAR_W'($urandom_range(33, 126));
    endfunction

    // Well-formed text with random content: words, blank runs of mixed length,
    // newlines, flushes (with a random ignored byte) and some raw noise bytes.
    task automatic send_random_text(input int unsigned n_requests);
        int unsigned stop_at = requests_sent + n_requests;
        int unsigned pick;
        int unsigned len;
        while (requests_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = $urandom_range(1, 6);
                repeat (len) send_request(rand_text_char(), 1'b0);
            end else if (pick < 75) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 24) : $urandom_range(1, 4);
                repeat (len) send_request(CH_BLANK, 1'b0);
            end else if (pick < 85) begin
                send_request(CH_NEWLINE, 1'b0);
            end else if (pick < 90) begin
                send_request(CHAR_W'($urandom_range(0, 255)), 1'b1);
            end else begin
                send_request(CHAR_W'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Byte extremes, single blanks, runs with and without a stop crossed,
    // a run closed by newline, and flushes with nothing, one or many blanks pending.
    task automatic test_directed_text();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_tab_width(TAB_WIDTH_RESET);
        send_request("a", 1'b0);
        send_request(CH_BLANK, 1'b0);
        send_request("b", 1'b0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        repeat (5) send_request(CH_BLANK, 1'b0);    // run from column 5 crosses column 8
        send_request("x", 1'b0);
        repeat (2) send_request(CH_BLANK, 1'b0);    // short run, no stop crossed
        send_request("y", 1'b0);
        repeat (3) send_request(CH_BLANK, 1'b0);
        send_request(CH_NEWLINE, 1'b0);             // newline closes the run
        send_request(8'h00, 1'b1);                  // flush with nothing pending
        send_request(CH_BLANK, 1'b0);
        send_request(8'hFF, 1'b1);                  // flush a single blank
        repeat (3) send_request(CH_BLANK, 1'b0);
        send_request(CH_BLANK, 1'b1);               // flush a run; its byte is ignored
    endtask

    // Change the width while a run is pending: the new width applies on emission.
    // The sender also pauses here until every predicted byte has come out.
    task automatic test_tab_width_change();
        send_idle_pct  = 20;
        recv_stall_pct = 40;
        drain_results();
        write_tab_width(5'd8);
        repeat (6) send_request(CH_BLANK, 1'b0);
        drain_results();
        write_tab_width(5'd3);
        send_request("z", 1'b0);
        repeat (7) send_request(CH_BLANK, 1'b0);
        drain_results();
        write_tab_width(5'd0);
        send_request(CH_NEWLINE, 1'b0);
    endtask

    // Short random lines at each notable width, extremes and out-of-range included
    task automatic test_tab_width_sweep();
        logic [TW_W-1:0] widths[7] = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd16, 5'd3, 5'd5};
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        foreach (widths[k]) begin
            drain_results();
            write_tab_width(widths[k]);
            send_random_text(1);
            send_request(CH_NEWLINE, 1'b0);
        end
    endtask

    // Drive the column into saturation with a long blank run, so that blanks are
    // lost and the tab count must be trimmed to fit one request's output.
    task automatic send_saturating_line(input logic [TW_W-1:0] width,
                                        input int unsigned lead,
                                        input int unsigned blanks,
                                        input logic [CHAR_W-1:0] closer);
        drain_results();
        write_tab_width(width);
        send_request(8'h00, 1'b1);
        repeat (lead) send_request(rand_text_char(), 1'b0);
        repeat (blanks) send_request(CH_BLANK, 1'b0);
        send_request(closer, 1'b0);
    endtask

    // Run from column 205 holds at the last column after 50 blanks, the rest are
    // lost; its 50 stops at width one are trimmed to 38 tabs.
    task automatic test_saturated_lines();
        send_idle_pct  = 0;
        recv_stall_pct = 25;
        send_saturating_line(5'd1, 205, 53, CH_NEWLINE);
        send_request(8'h20, 1'b1);
    endtask

    // Random text across the idling phases, with a drain in the middle of each
    task automatic test_random_text();
        int send_pct[4] = '{0, 87, 0, 28};
        int recv_pct[4] = '{0, 0, 87, 28};
        for (int phase = 0; phase < 4; phase++) begin
            drain_results();
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            write_tab_width(TW_W'($urandom_range(0, 31)));
            send_random_text(4);
            drain_results();
            send_random_text(4);
        end
    endtask

    // ---------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ---------------------------------------------------------------------

    // Stall o_out at the phase's rate
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Compare every accepted output byte with the oldest prediction
    always @(posedge i_clk) begin : check_output
        t_out_byte want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_out.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected output: char %02h last %0b",
                             out_if.out_char, out_if.last);
                end
            end else begin
                want = expected_out.pop_front();
                if (want.out_char !== out_if.out_char || want.last !== out_if.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("mismatch: expected char %02h last %0b, got %02h last %0b",
                                 want.out_char, want.last, out_if.out_char, out_if.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("blank_run_to_tab_compressor_tb: FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------------

    initial begin
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        requests_sent      = 0;
        i_rst_n           <= 1'b0;
        i_tab_width_we    <= 1'b0;
        i_tab_width_wdata <= '0;
        in_if.valid       <= 1'b0;
        in_if.in_char     <= '0;
        in_if.flush       <= 1'b0;
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_text();
        test_tab_width_change();
        test_tab_width_sweep();
        test_saturated_lines();
        test_random_text();

        drain_results();
        if (mismatch_count == 0 && expected_out.size() == 0) begin
            $display("blank_run_to_tab_compressor_tb: PASS");
        end else begin
            $display("blank_run_to_tab_compressor_tb: FAIL");
        end
        $finish;
    end

endmodule
